[hdl/vn3_pkg.sv]
package vn3_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned NoiseW = 32;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned PipeDepth = 15;

  localparam logic [31:0] HashMulA = 32'd15731;
  localparam logic [31:0] HashAddB = 32'd789221;
  localparam logic [31:0] HashAddC = 32'd1376312589;
  localparam logic [31:0] HashMask = 32'h7fffffff;
  localparam logic [19:0] ChainScale = 20'd850000;

  // Pre-hash mixing step of the lattice hash.
  function automatic logic [31:0] hash_mix(input logic [31:0] t);
    return (t << 13) ^ t;
  endfunction

endpackage

[hdl/vn3_stream_if.sv]
interface vn3_stream_if #(
  parameter int unsigned Width = 32
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/value_noise_3d_trilinear_top.sv]
// 3D value noise with trilinear blending, fully pipelined.
//
// Input channel in_i carries one point per item: data holds {coord_z, coord_y,
// coord_x}, each a signed 32-bit fixed-point value with CoordFracBits fraction
// bits. Output channel out_o carries the noise value, unsigned Q1.31, where
// 32'h80000000 means 1.0; every input item yields exactly one output item.
//
// The block takes one item per cycle while out_o is not stalling it. The three
// chained hashes of the eight corners each take three multiply stages, the
// chain scaling of the x and y hashes takes one more each, and the three blend
// levels take one product stage each.
//
// The pipeline advances as a whole whenever its last stage is empty or being
// taken, so when the receiver stalls every stage holds its item and in_i.ready
// falls once the final stage is full. Nothing is lost or repeated.
//
// Reset clears all valid bits; data registers are not reset. The block holds
// no other state.
module value_noise_3d_trilinear_top #(
  parameter int unsigned CoordFracBits = vn3_pkg::FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vn3_stream_if.sink   in_i,
  vn3_stream_if.source out_o
);

  localparam int unsigned FB = CoordFracBits;
  localparam int unsigned ND = vn3_pkg::PipeDepth;

  // Stage numbering.
  //  1: split, corner indices; 2..4 x hash; 5 x scale; 6..8 y hash;
  //  9 y scale; 10..12 z hash and corner values; 13,14,15 blends.

  logic [ND:1] vld_q;
  logic        adv;

  assign adv = !vld_q[ND] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[ND-1:1], in_i.valid};
    end
  end

  // Fractions travel to the blend stages.
  logic [FB-1:0] fx_q [1:14];
  logic [FB-1:0] fy_q [1:14];
  logic [FB-1:0] fz_q [1:14];

  // Stage 1: split.
  logic [31:0] ix_q, iy_q, iz_q;
  logic [31:0] cx, cy, cz;
  assign cx = in_i.data[31:0];
  assign cy = in_i.data[63:32];
  assign cz = in_i.data[95:64];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ix_q <= 32'($signed(cx) >>> FB);
      iy_q <= 32'($signed(cy) >>> FB);
      iz_q <= 32'($signed(cz) >>> FB);
      fx_q[1] <= cx[FB-1:0];
      fy_q[1] <= cy[FB-1:0];
      fz_q[1] <= cz[FB-1:0];
      for (int s = 2; s <= 14; s++) begin
        fx_q[s] <= fx_q[s-1];
        fy_q[s] <= fy_q[s-1];
        fz_q[s] <= fz_q[s-1];
      end
    end
  end

  // Per-axis hash state. The x hash has 2 variants, y input 4, z input 8.
  // Hash pipeline: h1 = mix(t); h2 = h1*h1; h3 = h2*A + B; h4 = (h1*h3 + C) & mask.
  // Stage split: A: mix and square; B: times A plus B; C: final product.

  // x chain (2 corners: ix, ix+1).
  logic [31:0] xh1_q [2], xsq_q [2], xh1b_q [2], xin_q [2], xm_q [2];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) begin
        // stage 2
        xh1_q[k] <= vn3_pkg::hash_mix(ix_q + 32'(k));
        xsq_q[k] <= vn3_pkg::hash_mix(ix_q + 32'(k)) * vn3_pkg::hash_mix(ix_q + 32'(k));
        // stage 3
        xh1b_q[k] <= xh1_q[k];
        xin_q[k] <= xsq_q[k] * vn3_pkg::HashMulA + vn3_pkg::HashAddB;
        // stage 4
        xm_q[k] <= (xh1b_q[k] * xin_q[k] + vn3_pkg::HashAddC) & vn3_pkg::HashMask;
      end
    end
  end

  // Simple delay lines for iy (to stage 5) and iz (to stage 9).
  logic [31:0] iyd_q [2:5];
  logic [31:0] izd_q [2:9];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      iyd_q[2] <= iy_q;
      izd_q[2] <= iz_q;
      for (int s = 3; s <= 5; s++) iyd_q[s] <= iyd_q[s-1];
      for (int s = 3; s <= 9; s++) izd_q[s] <= izd_q[s-1];
    end
  end

  // Chain scaling: trunc((2^30 - m) * 850000 / 2^30).
  function automatic logic [31:0] chain_scale(input logic [31:0] m);
    logic signed [31:0] s;
    logic signed [52:0] p;
    logic [52:0] mag;
    logic [52:0] q;
    begin
      s = 32'sh40000000 - $signed(m);
      p = 53'(s) * $signed({1'b0, vn3_pkg::ChainScale});
      mag = p[52] ? 53'(-p) : 53'(p);
      q = mag >> 30;
      chain_scale = p[52] ? 32'(-q) : 32'(q);
    end
  endfunction

  // Stage 5: x scale.
  logic [31:0] hx_q [2];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) hx_q[k] <= chain_scale(xm_q[k]);
    end
  end

  // y chain: corner j = {dy, dx}, input hx[dx] + iy + dy.
  logic [31:0] yh1_q [4], ysq_q [4], yh1b_q [4], yin_q [4], ym_q [4], hy_q [4];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        yh1_q[j] <= vn3_pkg::hash_mix(hx_q[j%2] + iyd_q[5] + 32'(j/2));
        ysq_q[j] <= vn3_pkg::hash_mix(hx_q[j%2] + iyd_q[5] + 32'(j/2))
                  * vn3_pkg::hash_mix(hx_q[j%2] + iyd_q[5] + 32'(j/2));
        yh1b_q[j] <= yh1_q[j];
        yin_q[j] <= ysq_q[j] * vn3_pkg::HashMulA + vn3_pkg::HashAddB;
        ym_q[j] <= (yh1b_q[j] * yin_q[j] + vn3_pkg::HashAddC) & vn3_pkg::HashMask;
        hy_q[j] <= chain_scale(ym_q[j]);
      end
    end
  end

  // z chain: corner c = {dz, dy, dx}; corner value 2^31 - m.
  logic [31:0] zh1_q [8], zsq_q [8], zh1b_q [8], zin_q [8];
  logic [31:0] corner_q [8];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 8; c++) begin
        zh1_q[c] <= vn3_pkg::hash_mix(hy_q[c%4] + izd_q[9] + 32'(c/4));
        zsq_q[c] <= vn3_pkg::hash_mix(hy_q[c%4] + izd_q[9] + 32'(c/4))
                  * vn3_pkg::hash_mix(hy_q[c%4] + izd_q[9] + 32'(c/4));
        zh1b_q[c] <= zh1_q[c];
        zin_q[c] <= zsq_q[c] * vn3_pkg::HashMulA + vn3_pkg::HashAddB;
        corner_q[c] <= 32'h80000000
          - ((zh1b_q[c] * zin_q[c] + vn3_pkg::HashAddC) & vn3_pkg::HashMask);
      end
    end
  end

  // Blend: a + trunc((b - a) * f / 2^FB).
  function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                        input logic [FB-1:0] f);
    logic signed [32:0] dif;
    logic signed [33+FB:0] p;
    logic [33+FB:0] mag;
    logic [33+FB:0] q;
    begin
      dif = $signed({1'b0, b}) - $signed({1'b0, a});
      p = (34+FB)'(dif) * $signed({1'b0, f});
      mag = p[33+FB] ? (34+FB)'(-p) : (34+FB)'(p);
      q = mag >> FB;
      blend = p[33+FB] ? a - 32'(q) : a + 32'(q);
    end
  endfunction

  // Stages 13..15: blend in x, y, z.
  logic [31:0] bx_q [4], by_q [2], res_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) bx_q[j] <= blend(corner_q[2*j], corner_q[2*j+1], fx_q[12]);
      for (int j = 0; j < 2; j++) by_q[j] <= blend(bx_q[2*j], bx_q[2*j+1], fy_q[13]);
      res_q <= blend(by_q[0], by_q[1], fz_q[14]);
    end
  end

  assign out_o.valid = vld_q[ND];
  assign out_o.data  = res_q;

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.data))
    else $error("output item changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready == (!out_o.valid || out_o.ready))
    else $error("input ready does not follow pipeline advance");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data != 32'd0 && out_o.data <= 32'h80000000))
    else $error("noise value out of range");
`endif

endmodule
